FILE: hdl/grcs_pkg.sv
// ---------------------------------------------------------------------------
// grcs_pkg: shared types and constants of the grid raycast column shader
// sine table, fixed march step and shade codes
// ---------------------------------------------------------------------------
package grcs_pkg;

  localparam int unsigned STEP_Q11 = 205;

  typedef logic [2:0] shade_t;
  localparam shade_t SHADE_SPACE  = 3'd0;
  localparam shade_t SHADE_FULL   = 3'd1;
  localparam shade_t SHADE_DARK   = 3'd2;
  localparam shade_t SHADE_MEDIUM = 3'd3;
  localparam shade_t SHADE_LIGHT  = 3'd4;
  localparam shade_t SHADE_HASH   = 3'd5;
  localparam shade_t SHADE_X      = 3'd6;
  localparam shade_t SHADE_DOT    = 3'd7;

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_PLAYER_X   = 3'd0;
  localparam cfg_idx_t CFG_PLAYER_Y   = 3'd1;
  localparam cfg_idx_t CFG_ANGLE      = 3'd2;
  localparam cfg_idx_t CFG_MAX_DEPTH  = 3'd3;
  localparam cfg_idx_t CFG_MAP_A      = 3'd4;
  localparam cfg_idx_t CFG_MAP_B      = 3'd5;
  localparam cfg_idx_t CFG_MAP_C      = 3'd6;
  localparam cfg_idx_t CFG_MAP_D      = 3'd7;

  // quarter-wave sine, q1.14
  function automatic logic [14:0] sine_tab(input logic [4:0] i);
    case (i)
      5'd0: sine_tab = 15'd0;
      5'd1: sine_tab = 15'd1606;
      5'd2: sine_tab = 15'd3196;
      5'd3: sine_tab = 15'd4756;
      5'd4: sine_tab = 15'd6270;
      5'd5: sine_tab = 15'd7723;
      5'd6: sine_tab = 15'd9102;
      5'd7: sine_tab = 15'd10394;
      5'd8: sine_tab = 15'd11585;
      5'd9: sine_tab = 15'd12665;
      5'd10: sine_tab = 15'd13623;
      5'd11: sine_tab = 15'd14449;
      5'd12: sine_tab = 15'd15137;
      5'd13: sine_tab = 15'd15678;
      5'd14: sine_tab = 15'd16069;
      5'd15: sine_tab = 15'd16305;
      default: sine_tab = 15'd16384;
    endcase
  endfunction

endpackage

FILE: hdl/grcs_col_if.sv
// ---------------------------------------------------------------------------
// grcs_col_if: column request channel
// valid/ready handshake carrying one screen column
// ---------------------------------------------------------------------------
interface grcs_col_if;
  logic       valid;
  logic       ready;
  logic [6:0] column;
  modport source (output valid, output column, input ready);
  modport sink   (input valid, input column, output ready);
endinterface

FILE: hdl/grcs_row_if.sv
// ---------------------------------------------------------------------------
// grcs_row_if: row result channel
// valid/ready handshake carrying one shaded row
// ---------------------------------------------------------------------------
interface grcs_row_if;
  logic        valid;
  logic        ready;
  logic [5:0]  row;
  logic [2:0]  shade_code;
  logic [14:0] wall_distance;
  logic        last_row;
  modport source (output valid, output row, output shade_code, output wall_distance,
                  output last_row, input ready);
  modport sink   (input valid, input row, input shade_code, input wall_distance,
                  input last_row, output ready);
endinterface

FILE: hdl/grcs_div.sv
// ---------------------------------------------------------------------------
// grcs_div: radix-2 restoring divider
// unsigned quotient, one bit per cycle
// ---------------------------------------------------------------------------
module grcs_div #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  q_r, d_r;
  logic [W:0]    rem_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic [W:0]    trial;

  assign trial    = {rem_r[W-1:0], q_r[W-1]} - {1'b0, d_r};
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        q_r    <= dividend;
        d_r    <= divisor;
        rem_r  <= '0;
        cnt_r  <= CW'(W);
      end else if (busy_r) begin
        if (!trial[W]) begin
          rem_r <= trial;
          q_r   <= {q_r[W-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[W-1:0], q_r[W-1]};
          q_r   <= {q_r[W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
endmodule

FILE: hdl/grid_raycast_column_shader_top.sv
// ---------------------------------------------------------------------------
// grid_raycast_column_shader_top: casts one ray per screen column
// marches a 16x16 wall map and emits one shade code per screen row
// ---------------------------------------------------------------------------
// Each request names a screen column. The block derives the ray angle (the
// column*fov/columns quotient comes from a constant split plus a reciprocal
// multiply), then looks up sine and cosine by interpolating a quarter-wave
// table through one shared multiplier. It then marches in steps of 205/2048
// cell, using the same multiplier twice per step (x and y offsets) plus one
// map probe, up to 160 steps at the largest depth. A shade state picks the
// wall shade and one pass of the divider gives the ceiling row, then
// SCREEN_ROWS results leave one per cycle while the sink takes them. The
// block takes no new request until the last row of the column has been taken.
module grid_raycast_column_shader_top #(
  parameter int SCREEN_COLUMNS = 120,
  parameter int SCREEN_ROWS    = 40,
  parameter int MAP_SIZE       = 16,
  parameter int FOV_ANGLE      = 8192
) (
  input  logic        clk,
  input  logic        rst_n,
  grcs_col_if.sink    in_col,
  grcs_row_if.source  out_row,
  input  logic        cfg_we,
  input  grcs_pkg::cfg_idx_t cfg_index,
  input  logic [63:0] cfg_data
);
  import grcs_pkg::*;

  localparam int DW = 32;

  // column*fov/columns = column*FOV_Q + column*FOV_R/columns, the last by reciprocal
  localparam logic [15:0] FOV_Q = 16'(FOV_ANGLE / SCREEN_COLUMNS);
  localparam logic [9:0]  FOV_R = 10'(FOV_ANGLE % SCREEN_COLUMNS);
  localparam int RK = 28;
  localparam logic [28:0] RECIP =
    29'(((64'd1 << RK) + 64'(SCREEN_COLUMNS) - 64'd1) / 64'(SCREEN_COLUMNS));

  typedef enum logic [3:0] {
    S_IDLE, S_ADIV, S_AWAIT, S_TRIG, S_STEP, S_MX, S_MY,
    S_CDIV, S_CWAIT, S_EMIT
  } state_t;

  // configuration registers
  logic [14:0] px_r, py_r, dmax_cfg_r;
  logic [15:0] pang_r;
  logic [63:0] map_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      px_r <= 15'd16384; py_r <= 15'd16384; pang_r <= '0; dmax_cfg_r <= 15'd32767;
      map_r[0] <= '0; map_r[1] <= '0; map_r[2] <= '0; map_r[3] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PLAYER_X:  px_r <= cfg_data[14:0];
        CFG_PLAYER_Y:  py_r <= cfg_data[14:0];
        CFG_ANGLE:     pang_r <= cfg_data[15:0];
        CFG_MAX_DEPTH: dmax_cfg_r <= cfg_data[14:0];
        CFG_MAP_A:     map_r[0] <= cfg_data;
        CFG_MAP_B:     map_r[1] <= cfg_data;
        CFG_MAP_C:     map_r[2] <= cfg_data;
        CFG_MAP_D:     map_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t      state_r;
  logic [6:0]  col_r;
  logic [16:0] anum_r;           // column * (fov mod columns)
  logic [15:0] ang_r;
  logic        tph_r;            // trig phase: sine, then cosine
  logic        exn_r, eyn_r;
  logic [14:0] ex_mag_r, ey_mag_r;
  logic [14:0] dmax_r, d_r;
  logic [15:0] offx_r;           // magnitude of x offset
  logic signed [11:0] ceil_r;    // reaches about -10*rows at the shortest distance
  logic [5:0]  row_r;
  logic [2:0]  wshade_r;
  logic        ovalid_r;

  // divider for the ceiling row
  logic          dv_start, dv_done;
  logic [DW-1:0] dv_a, dv_b, dv_q;
  grcs_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .dividend(dv_a), .divisor(dv_b),
    .done(dv_done), .quotient(dv_q)
  );

  // ray angle offset
  logic [15:0] abase;
  logic [45:0] aprod;
  assign abase = 16'({9'd0, col_r} * FOV_Q);
  assign aprod = {29'd0, anum_r} * {17'd0, RECIP};

  // shared multiplier: 15 x 15 unsigned
  logic [14:0] mul_a, mul_b;
  logic [29:0] mul_p;
  assign mul_p = mul_a * mul_b;

  // trig interpolation front end
  logic [15:0] tang;
  logic [13:0] tw;
  logic [14:0] tw15;
  logic [4:0]  ti;
  logic [9:0]  tf;
  logic [14:0] ts0, ts1;
  assign tang = tph_r ? ang_r + 16'd16384 : ang_r;
  assign tw   = tang[13:0];
  assign tw15 = tang[14] ? 15'd16384 - {1'b0, tw} : {1'b0, tw};
  assign ti   = tw15[14:10];
  assign tf   = tw15[9:0];
  assign ts0  = sine_tab(ti);
  assign ts1  = sine_tab(ti + 5'd1);

  logic [14:0] tval;
  assign tval = (tw15 >= 15'd16384) ? 15'd16384 : ts0 + 15'(mul_p >> 10);

  // march offsets: floor for positive, ceil of magnitude for negative
  logic [15:0] offm;
  logic        curn;
  assign curn = (state_r == S_MX) ? exn_r : eyn_r;
  assign offm = curn ? 16'((mul_p + 30'd16383) >> 14) : 16'(mul_p >> 14);

  logic signed [17:0] cx, cy;
  assign cx = exn_r ? $signed({3'b0, px_r}) - $signed({2'b0, offx_r})
                    : $signed({3'b0, px_r}) + $signed({2'b0, offx_r});
  assign cy = eyn_r ? $signed({3'b0, py_r}) - $signed({2'b0, offm})
                    : $signed({3'b0, py_r}) + $signed({2'b0, offm});

  localparam int LIM = MAP_SIZE * 2048;
  logic outside, wallbit;
  logic [3:0] cellx, celly;
  assign outside = cx < 0 || cy < 0 || cx >= LIM || cy >= LIM;
  assign cellx = cx[14:11];
  assign celly = cy[14:11];
  assign wallbit = map_r[celly[3:2]][{celly[1:0], cellx}];

  always_comb begin
    mul_a = '0; mul_b = '0;
    case (state_r)
      S_TRIG:  begin mul_a = ts1 - ts0; mul_b = {5'd0, tf}; end
      S_MX:    begin mul_a = ex_mag_r; mul_b = d_r; end
      S_MY:    begin mul_a = ey_mag_r; mul_b = d_r; end
      default: ;
    endcase
  end

  logic [14:0] dnext;
  logic [15:0] dsum;
  assign dsum  = {1'b0, d_r} + 16'(STEP_Q11);
  assign dnext = (dsum > {1'b0, dmax_r}) ? dmax_r : dsum[14:0];

  // ceiling divide: R*d - 4096R over 2d, truncating toward zero
  logic signed [DW-1:0] cnum;
  logic [DW-1:0] cmag;
  assign cnum = DW'(SCREEN_ROWS) * $signed({17'd0, d_r}) - DW'(4096 * SCREEN_ROWS);
  assign cmag = cnum[DW-1] ? -cnum : cnum;

  always_comb begin
    dv_start = 1'b0; dv_a = '0; dv_b = '0;
    case (state_r)
      S_CDIV: begin
        dv_start = 1'b1;
        dv_a = cmag;
        dv_b = {16'd0, d_r, 1'b0};
      end
      default: ;
    endcase
  end

  // row shading
  logic [15:0] y8, y4;
  logic [2:0]  sh;
  logic signed [11:0] ys;
  assign ys = $signed({6'b0, row_r});
  assign y8 = 16'(row_r) * 16'd8;
  assign y4 = 16'(row_r) * 16'd4;
  always_comb begin
    if (ys > ceil_r && ys <= 12'(SCREEN_ROWS) - ceil_r) sh = wshade_r;
    else if (y8 > 16'(7 * SCREEN_ROWS)) sh = SHADE_HASH;
    else if (y4 > 16'(3 * SCREEN_ROWS)) sh = SHADE_X;
    else if (y8 > 16'(5 * SCREEN_ROWS)) sh = SHADE_DOT;
    else sh = SHADE_SPACE;
  end

  logic [16:0] d4, d3, d2;
  assign d4 = {d_r, 2'b0};
  assign d3 = 17'(d_r) + {1'b0, d_r, 1'b0};
  assign d2 = {1'b0, d_r, 1'b0};

  logic last;
  assign last = row_r == 6'(SCREEN_ROWS - 1);

  assign in_col.ready          = state_r == S_IDLE;
  assign out_row.valid         = ovalid_r;
  assign out_row.row           = row_r;
  assign out_row.shade_code    = sh;
  assign out_row.wall_distance = d_r;
  assign out_row.last_row      = last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      tph_r    <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_col.valid) begin
          col_r   <= in_col.column;
          dmax_r  <= (dmax_cfg_r < 15'(STEP_Q11)) ? 15'(STEP_Q11) : dmax_cfg_r;
          state_r <= S_ADIV;
        end
        S_ADIV: begin
          anum_r  <= 17'({10'd0, col_r} * {7'd0, FOV_R});
          state_r <= S_AWAIT;
        end
        S_AWAIT: begin
          ang_r   <= pang_r - 16'(FOV_ANGLE / 2) + abase + aprod[RK+15:RK];
          tph_r   <= 1'b0;
          state_r <= S_TRIG;
        end
        S_TRIG: begin
          if (!tph_r) begin
            ex_mag_r <= tval; exn_r <= tang[15] && tval != 0;
            tph_r    <= 1'b1;
          end else begin
            ey_mag_r <= tval; eyn_r <= tang[15] && tval != 0;
            d_r      <= '0;
            state_r  <= S_STEP;
          end
        end
        S_STEP: begin
          d_r     <= dnext;
          state_r <= S_MX;
        end
        S_MX: begin
          offx_r  <= offm;
          state_r <= S_MY;
        end
        S_MY: begin
          if (outside) begin
            d_r <= dmax_r; state_r <= S_CDIV;
          end else if (wallbit || d_r >= dmax_r) begin
            state_r <= S_CDIV;
          end else begin
            state_r <= S_STEP;
          end
        end
        S_CDIV: begin
          if (d4 <= 17'(dmax_r))      wshade_r <= SHADE_FULL;
          else if (d3 < 17'(dmax_r))  wshade_r <= SHADE_DARK;
          else if (d2 < 17'(dmax_r))  wshade_r <= SHADE_MEDIUM;
          else if (d_r < dmax_r)      wshade_r <= SHADE_LIGHT;
          else                        wshade_r <= SHADE_SPACE;
          state_r <= S_CWAIT;
        end
        S_CWAIT: if (dv_done) begin
          ceil_r   <= cnum[DW-1] ? -$signed(12'(dv_q)) : $signed(12'(dv_q));
          row_r    <= '0;
          ovalid_r <= 1'b1;
          state_r  <= S_EMIT;
        end
        S_EMIT: if (out_row.ready) begin
          if (last) begin
            ovalid_r <= 1'b0;
            state_r  <= S_IDLE;
          end else begin
            row_r <= row_r + 6'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: tb/sv/grcs_tb_if.sv
// ---------------------------------------------------------------------------
// grcs_tb_if: testbench constants package and note on channel interfaces
// the column and row channel interfaces come with the rtl and are reused here
// ---------------------------------------------------------------------------
package grcs_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;

  // rows per column, matches the block's default
  localparam int unsigned ROWS = 40;
  localparam int unsigned COLUMNS = 120;
  localparam int unsigned FOV = 8192;
endpackage

FILE: tb/sv/grcs_checker.sv
// ---------------------------------------------------------------------------
// grcs_checker: row shade predictor and scoreboard
// recomputes every row of each accepted column and compares the results
// ---------------------------------------------------------------------------
module grcs_checker
  import grcs_pkg::*;
  import grcs_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        col_valid,
  input  logic        col_ready,
  input  logic [6:0]  col_column,
  input  logic        row_valid,
  input  logic        row_ready,
  input  logic [5:0]  row_row,
  input  shade_t      row_shade,
  input  logic [14:0] row_dist,
  input  logic        row_last,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [63:0] cfg_data,
  output int          fail_count,
  output int          rows_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [5:0]  row;
    shade_t      shade;
    logic [14:0] wall_dist;
    logic        last;
  } shaded_row_t;

  shaded_row_t expected_rows[$];
  logic [14:0] view_x, view_y, depth_limit;
  logic [15:0] view_angle;
  logic [63:0] wall_map[4];

  localparam int unsigned SINE_Q[17] = '{0, 1606, 3196, 4756, 6270, 7723, 9102, 10394,
    11585, 12665, 13623, 14449, 15137, 15678, 16069, 16305, 16384};

  function automatic int sine_q14(logic [15:0] a);
    logic [1:0] quad;
    int unsigned w, i, v;
    quad = a[15:14];
    w = a[13:0];
    if (quad[0]) w = 16384 - w;
    if (w >= 16384) v = SINE_Q[16];
    else begin
      i = w >> 10;
      v = SINE_Q[i] + (((SINE_Q[i+1] - SINE_Q[i]) * (w & 1023)) >> 10);
    end
    return quad[1] ? -int'(v) : int'(v);
  endfunction

  function automatic int ray_offset(int dir, int d);
    int p;
    p = dir * d;
    if (p >= 0) return p >>> 14;
    return -int'((unsigned'(-p) + 16383) >> 14);
  endfunction

  // 0 open, 1 wall, 2 off the map
  function automatic int map_probe(int px, int py);
    int cx, cy;
    if (px < 0 || py < 0 || px >= 16 * 2048 || py >= 16 * 2048) return 2;
    cx = px >> 11;
    cy = py >> 11;
    return wall_map[cy >> 2][(cy & 3) * 16 + cx];
  endfunction

  task automatic shade_column(logic [6:0] col);
    logic [15:0] ang;
    int ex, ey, d, dmax, r, ceil_row, floor_row, y;
    bit hit;
    shade_t wall_shade, s;
    shaded_row_t e;
    ang = view_angle - 16'(FOV / 2) + 16'((int'(col) * FOV) / COLUMNS);
    ex = sine_q14(ang);
    ey = sine_q14(ang + 16'd16384);
    dmax = depth_limit < STEP_Q11 ? STEP_Q11 : depth_limit;
    d = 0;
    hit = 0;
    while (!hit && d < dmax) begin
      d += STEP_Q11;
      if (d > dmax) d = dmax;
      r = map_probe(int'(view_x) + ray_offset(ex, d), int'(view_y) + ray_offset(ey, d));
      if (r == 2) begin
        hit = 1;
        d = dmax;
      end else if (r == 1) begin
        hit = 1;
      end
    end
    ceil_row = (int'(ROWS) * d - 4096 * int'(ROWS)) / (2 * d);
    floor_row = int'(ROWS) - ceil_row;
    if (4 * d <= dmax) wall_shade = SHADE_FULL;
    else if (3 * d < dmax) wall_shade = SHADE_DARK;
    else if (2 * d < dmax) wall_shade = SHADE_MEDIUM;
    else if (d < dmax) wall_shade = SHADE_LIGHT;
    else wall_shade = SHADE_SPACE;
    for (y = 0; y < ROWS; y++) begin
      if (y > ceil_row && y <= floor_row) s = wall_shade;
      else if (8 * y > 7 * ROWS) s = SHADE_HASH;
      else if (4 * y > 3 * ROWS) s = SHADE_X;
      else if (8 * y > 5 * ROWS) s = SHADE_DOT;
      else s = SHADE_SPACE;
      e.row = 6'(y);
      e.shade = s;
      e.wall_dist = d[14:0];
      e.last = (y == ROWS - 1);
      expected_rows.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    shaded_row_t e;
    if (!rst_n) begin
      view_x <= 15'd16384;
      view_y <= 15'd16384;
      view_angle <= '0;
      depth_limit <= 15'd32767;
      for (int k = 0; k < 4; k++) wall_map[k] <= '0;
      fail_count <= 0;
      rows_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PLAYER_X:  view_x <= cfg_data[14:0];
          CFG_PLAYER_Y:  view_y <= cfg_data[14:0];
          CFG_ANGLE:     view_angle <= cfg_data[15:0];
          CFG_MAX_DEPTH: depth_limit <= cfg_data[14:0];
          CFG_MAP_A:     wall_map[0] <= cfg_data;
          CFG_MAP_B:     wall_map[1] <= cfg_data;
          CFG_MAP_C:     wall_map[2] <= cfg_data;
          CFG_MAP_D:     wall_map[3] <= cfg_data;
          default: ;
        endcase
      end
      if (col_valid && col_ready) shade_column(col_column);
      if (row_valid && row_ready) begin
        if (expected_rows.size() == 0) begin
          if (fail_count < 10) $display("unexpected row %0d shade %0d", row_row, row_shade);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_rows.pop_front();
          if (e.row !== row_row || e.shade !== row_shade || e.wall_dist !== row_dist ||
              e.last !== row_last) begin
            if (fail_count < 10)
              $display("row mismatch exp row %0d shade %0d dist %0d last %0d, got %0d %0d %0d %0d",
                       e.row, e.shade, e.wall_dist, e.last, row_row, row_shade, row_dist,
                       row_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      rows_pending <= expected_rows.size();
    end
  end
endmodule

FILE: tb/sv/grid_raycast_column_shader_top_tb.sv
// ---------------------------------------------------------------------------
// grid_raycast_column_shader_top_tb: stimulus and verdict
// directed and random columns over several viewer and map settings
// ---------------------------------------------------------------------------
module grid_raycast_column_shader_top_tb;
  import grcs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  cfg_idx_t    cfg_index;
  logic [63:0] cfg_data;
  int          fail_count, rows_pending;
  int          cycle_count;
  bit          sink_calm, sink_hold, source_calm;

  grcs_col_if col_ch();
  grcs_row_if row_ch();

  grid_raycast_column_shader_top u_dut (
    .clk(clk), .rst_n(rst_n), .in_col(col_ch.sink), .out_row(row_ch.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  grcs_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .col_valid(col_ch.valid), .col_ready(col_ch.ready), .col_column(col_ch.column),
    .row_valid(row_ch.valid), .row_ready(row_ch.ready), .row_row(row_ch.row),
    .row_shade(row_ch.shade_code), .row_dist(row_ch.wall_distance),
    .row_last(row_ch.last_row), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .rows_pending(rows_pending)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // result sink: random stalls unless calm, or a long forced hold
  initial begin
    row_ch.ready = 0;
    forever begin
      @(posedge clk);
      if (sink_hold) row_ch.ready <= 0;
      else row_ch.ready <= sink_calm || ($urandom_range(99) >= 28);
    end
  end

  // runaway guard, generous against the slowest column times stalls
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 2_000_000) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // one write, with cfg_we dropped again before the next
  task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // sender: one column request, waits for its handshake; valid stays up for the next
  task automatic send_column(logic [6:0] col);
    while (!source_calm && $urandom_range(99) < 28) begin
      col_ch.valid <= 0;
      @(posedge clk);
    end
    col_ch.valid <= 1;
    col_ch.column <= col;
    do @(posedge clk); while (!col_ch.ready);
  endtask

  task automatic drain;
    col_ch.valid <= 0;
    @(posedge clk);
    while (rows_pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // random column, mostly inside the view, sometimes past its edge
  function automatic logic [6:0] pick_column();
    if ($urandom_range(9) == 0) return 7'($urandom_range(127, 120));
    return 7'($urandom_range(119));
  endfunction

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_PLAYER_X;
    cfg_data = 0;
    col_ch.valid = 0;
    col_ch.column = 0;
    sink_calm = 0;
    sink_hold = 0;
    source_calm = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty map from reset, ray leaves the map
    send_column(7'd0);
    send_column(7'd119);
    send_column(7'd60);
    send_column(7'd127);
    send_column(7'd120);
    drain();

    // bordered room, close walls and tiny depth
    write_reg(CFG_MAP_A, 64'hFFFF_8001_8001_8001);
    write_reg(CFG_MAP_B, 64'h8001_8001_8001_8001);
    write_reg(CFG_MAP_C, 64'h8001_8001_8001_8001);
    write_reg(CFG_MAP_D, 64'hFFFF_8001_8001_8001);
    write_reg(CFG_MAX_DEPTH, 64'd0);
    send_column(7'd10);
    send_column(7'd100);
    drain();
    write_reg(CFG_MAX_DEPTH, 64'd205);
    send_column(7'd33);
    drain();
    write_reg(CFG_MAX_DEPTH, 64'd1000);
    write_reg(CFG_PLAYER_X, 64'd2100);
    write_reg(CFG_PLAYER_Y, 64'd30000);
    write_reg(CFG_ANGLE, 64'hFFFF);
    send_column(7'd0);
    send_column(7'd85);
    drain();
    write_reg(CFG_MAX_DEPTH, 64'h7FFF);
    write_reg(CFG_PLAYER_X, 64'h7FFF);
    write_reg(CFG_PLAYER_Y, 64'd0);
    write_reg(CFG_ANGLE, 64'd32768);
    send_column(7'd42);
    send_column(7'd127);
    drain();
    write_reg(CFG_MAP_A, '1);
    write_reg(CFG_MAP_B, '1);
    write_reg(CFG_MAP_C, '1);
    write_reg(CFG_MAP_D, '1);
    write_reg(CFG_PLAYER_X, 64'd16384);
    write_reg(CFG_PLAYER_Y, 64'd16384);
    send_column(7'd1);
    send_column(7'd64);
    drain();

    // random phases with fresh viewer and map each time
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CFG_MAP_A, {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(CFG_MAP_B, {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(CFG_MAP_C, {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(CFG_MAP_D, {$urandom, $urandom} & {$urandom, $urandom});
      write_reg(CFG_PLAYER_X, 64'($urandom_range(32767)));
      write_reg(CFG_PLAYER_Y, 64'($urandom_range(32767)));
      write_reg(CFG_ANGLE, 64'($urandom_range(65535)));
      write_reg(CFG_MAX_DEPTH, ph == 3 ? 64'd32767 : 64'($urandom_range(32767, 100)));
      sink_calm = (ph == 5);
      source_calm = (ph == 5);
      for (int k = 0; k < 30; k++) begin
        if (ph == 2 && k == 5) begin
          // hold the sink off while columns keep coming
          sink_hold = 1;
          fork
            begin
              int n;
              n = 0;
              while (n < 600) begin
                @(posedge clk);
                n++;
              end
              sink_hold = 0;
            end
          join_none
        end
        if (ph == 7 && k == 15) drain();
        send_column(pick_column());
      end
      drain();
    end

    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

FILE: files.f
hdl/grcs_pkg.sv
hdl/grcs_col_if.sv
hdl/grcs_row_if.sv
hdl/grcs_div.sv
hdl/grid_raycast_column_shader_top.sv
tb/sv/grcs_tb_if.sv
tb/sv/grcs_checker.sv
tb/sv/grid_raycast_column_shader_top_tb.sv
